### sv/multi_slot_advert_scheduler_defines.svh
// ----------------------------------------------------------------------------
// multi_slot_advert_scheduler_defines
// Assertion macros used by the scheduler controller (msas_ctrl). The macros
// expect a clock named clk and an active-low reset named arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_ADVERT_SCHEDULER_DEFINES_SVH
`define MULTI_SLOT_ADVERT_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSAS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSAS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

### sv/msas_pkg.sv
// ----------------------------------------------------------------------------
// msas_pkg
// Types and constants shared by the advertising slot scheduler modules.
// ----------------------------------------------------------------------------
package msas_pkg;

	// Table size and time step per tick.
	localparam int SLOTS     = 4;
	localparam int TICK_STEP = 10;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Field widths.
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 16;
	localparam int IVL_W   = 16;
	localparam int DLEN_W  = 5;
	localparam int FLEN_W  = 6;
	localparam int FIRED_W = 4;

	// Bytes added to the data length to give the frame length.
	localparam logic [FLEN_W-1:0] FRAME_EXTRA = 6'd8;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_LOAD     = 2'd1,
		REQ_STOP     = 2'd2,
		REQ_STOP_ALL = 2'd3
	} req_type_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic idx_clr;
		logic idx_inc;
		logic div_start;
		logic div_rec;
		logic emit;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tick_go;
		logic idx_last;
		logic iv_zero;
		logic mod_done;
		logic moment;
		logic due;
		logic out_free;
	} sts_t;

endpackage

### sv/msas_in_if.sv
// ----------------------------------------------------------------------------
// msas_in_if
// Request channel of the scheduler: valid/ready handshake and request fields.
// ----------------------------------------------------------------------------
interface msas_in_if;
	import msas_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [7:0]        slot;
	logic [CNT_W-1:0]  tx_count;
	logic [IVL_W-1:0]  interval;
	logic [DLEN_W-1:0] adv_len;

	modport source (output valid, req_type, slot, tx_count, interval, adv_len,
		input ready);
	modport sink (input valid, req_type, slot, tx_count, interval, adv_len,
		output ready);

endinterface

### sv/msas_out_if.sv
// ----------------------------------------------------------------------------
// msas_out_if
// Result channel of the scheduler: valid/ready handshake and send fields.
// ----------------------------------------------------------------------------
interface msas_out_if;
	import msas_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIRED_W-1:0] fired_slot;
	logic [FLEN_W-1:0]  frame_len;
	logic               last;

	modport source (output valid, fired_slot, frame_len, last, input ready);
	modport sink (input valid, fired_slot, frame_len, last, output ready);

endinterface

### sv/msas_rem.sv
// ----------------------------------------------------------------------------
// msas_rem
// Bit-serial remainder unit: 32-bit dividend over 16-bit divisor, one
// quotient bit per cycle, with a one-cycle done pulse at the end.
// ----------------------------------------------------------------------------
module msas_rem
	import msas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [IVL_W-1:0]  divisor,
	output logic              done,
	output logic              rem_zero
);

	localparam int CYC_W = $clog2(TIME_W);

	logic              busy_q;
	logic              done_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [TIME_W-1:0] dvd_q;
	logic [IVL_W-1:0]  dvs_q;
	logic [IVL_W-1:0]  rem_q;
	logic [IVL_W:0]    trial;
	logic [IVL_W:0]    diff;

	// Shift in the next dividend bit and try a subtraction.
	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// Control of the step sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cyc_q  <= '0;
			end else if (busy_q) begin
				cyc_q <= cyc_q + 1'b1;
				if (cyc_q == CYC_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[IVL_W-1:0];
			end else begin
				rem_q <= trial[IVL_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule

### sv/msas_dp.sv
// ----------------------------------------------------------------------------
// msas_dp
// Datapath of the scheduler: slot table, enable, time counter, divisibility
// flags, slot walker and the result register.
// ----------------------------------------------------------------------------
module msas_dp
	import msas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [1:0]        req_type,
	input  logic [7:0]        slot,
	input  logic [CNT_W-1:0]  tx_count,
	input  logic [IVL_W-1:0]  interval,
	input  logic [DLEN_W-1:0] adv_len,
	msas_out_if.source        res
);

	logic                enable_q;
	logic [TIME_W-1:0]   time_q;
	logic [CNT_W-1:0]    remain_q [SLOTS];
	logic [IVL_W-1:0]    ivl_q [SLOTS];
	logic [FLEN_W-1:0]   flen_q [SLOTS];
	logic [SLOTS-1:0]    div_q;
	logic [SLOT_W-1:0]   idx_q;
	logic                out_valid_q;
	logic [FIRED_W-1:0]  fired_q;
	logic [FLEN_W-1:0]   out_flen_q;
	logic                out_last_q;
	logic [SLOTS-1:0]    due_vec;
	logic                higher_due;
	logic                all_zero;
	logic                slot_ok;
	logic [SLOT_W-1:0]   slot_idx;
	logic                mod_done;
	logic                rem_zero;

	assign slot_ok  = (slot < 8'(SLOTS));
	assign slot_idx = slot[SLOT_W-1:0];

	// Due flags per slot, later dues and the all-counts-zero test.
	always_comb begin
		higher_due = 1'b0;
		all_zero   = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			due_vec[i] = (remain_q[i] != '0) && ((ivl_q[i] == '0) || div_q[i]);
			if (due_vec[i] && (SLOT_W'(i) > idx_q)) begin
				higher_due = 1'b1;
			end
			if (remain_q[i] != '0) begin
				all_zero = 1'b0;
			end
		end
	end

	// Remainder of the time counter by the current slot's interval.
	msas_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (time_q),
		.divisor  (ivl_q[idx_q]),
		.done     (mod_done),
		.rem_zero (rem_zero)
	);

	// Status to the controller.
	always_comb begin
		sts.tick_go  = (req_type == REQ_TICK) && enable_q;
		sts.idx_last = (idx_q == SLOT_W'(SLOTS - 1));
		sts.iv_zero  = (ivl_q[idx_q] == '0);
		sts.mod_done = mod_done;
		sts.moment   = |div_q;
		sts.due      = due_vec[idx_q];
		sts.out_free = !out_valid_q || res.ready;
	end

	// Slot table, enable and time counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			time_q   <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				remain_q[i] <= '0;
				ivl_q[i]    <= '0;
				flen_q[i]   <= '0;
			end
		end else begin
			if (cmd.accept) begin
				case (req_type_t'(req_type))
					REQ_LOAD: begin
						if ((tx_count != '0) && slot_ok) begin
							remain_q[slot_idx] <= tx_count;
							ivl_q[slot_idx]    <= interval;
							flen_q[slot_idx]   <= FLEN_W'(adv_len) + FRAME_EXTRA;
							enable_q           <= 1'b1;
						end
					end
					REQ_STOP: begin
						if (slot_ok) begin
							remain_q[slot_idx] <= '0;
						end
					end
					REQ_STOP_ALL: begin
						for (int i = 0; i < SLOTS; i++) begin
							remain_q[i] <= '0;
						end
						enable_q <= 1'b0;
					end
					REQ_TICK: begin
						if (enable_q) begin
							time_q <= time_q + TIME_W'(TICK_STEP);
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit) begin
				remain_q[idx_q] <= remain_q[idx_q] - 1'b1;
			end
			if (cmd.finish && all_zero) begin
				enable_q <= 1'b0;
			end
		end
	end

	// Slot walker and divisibility flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			div_q <= '0;
		end else begin
			if (cmd.div_rec) begin
				div_q[idx_q] <= (ivl_q[idx_q] != '0) && rem_zero;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Result register; a new result may load in the same cycle as the previous transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fired_q    <= FIRED_W'(idx_q);
			out_flen_q <= flen_q[idx_q];
			out_last_q <= !higher_due;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.fired_slot = fired_q;
	assign res.frame_len  = out_flen_q;
	assign res.last       = out_last_q;

endmodule

### sv/msas_ctrl.sv
// ----------------------------------------------------------------------------
// msas_ctrl
// Controller of the scheduler: takes requests, runs the divisibility pass
// over the slots and, if a flag is set, the send pass and the tick close.
// ----------------------------------------------------------------------------
`include "multi_slot_advert_scheduler_defines.svh"

module msas_ctrl
	import msas_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.tick_go) begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				if (!sts.iv_zero) begin
					state_d = ST_DIV_WAIT;
				end else if (sts.idx_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_DIV_WAIT: begin
				if (sts.mod_done) begin
					state_d = sts.idx_last ? ST_CHECK : ST_DIV_START;
				end
			end
			ST_CHECK: begin
				state_d = sts.moment ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if ((!sts.due || sts.out_free) && sts.idx_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept  = 1'b1;
					cmd.idx_clr = 1'b1;
				end
			end
			ST_DIV_START: begin
				if (!sts.iv_zero) begin
					cmd.div_start = 1'b1;
				end else begin
					cmd.div_rec = 1'b1;
					cmd.idx_clr = sts.idx_last;
					cmd.idx_inc = !sts.idx_last;
				end
			end
			ST_DIV_WAIT: begin
				if (sts.mod_done) begin
					cmd.div_rec = 1'b1;
					cmd.idx_clr = sts.idx_last;
					cmd.idx_inc = !sts.idx_last;
				end
			end
			ST_CHECK: begin
			end
			ST_SCAN: begin
				if (!sts.due || sts.out_free) begin
					cmd.emit    = sts.due;
					cmd.idx_inc = !sts.idx_last;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// A result is only loaded for a due slot and into a free result register.
	`MSAS_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free && sts.due)
	// The remainder unit only finishes while the controller waits for it.
	`MSAS_ASSERT_IMP(a_done_in_wait, sts.mod_done, state_q == ST_DIV_WAIT)
	// A started remainder never overlaps a recorded flag in the next cycle.
	`MSAS_ASSERT_NXT(a_start_then_wait, cmd.div_start, state_q == ST_DIV_WAIT && !cmd.div_rec)

endmodule

### sv/multi_slot_advert_scheduler.sv
// ----------------------------------------------------------------------------
// multi_slot_advert_scheduler
// Advertising slot scheduler: a table of slots with send counts, intervals
// and frame lengths, driven by tick, load and stop requests.
// ----------------------------------------------------------------------------
// Load, stop and stop-all requests and ticks while disabled take one cycle.
// A tick while enabled, once transferred, walks every slot with a nonzero
// interval through a bit-serial remainder unit and records a clear flag for
// a slot without one. A check state follows; if any slot's interval divides
// the time, a send pass over the slots, which stalls on a due slot while an
// untaken result is held, and a finish state close the tick. Results of a
// tick leave one per transfer in slot order, the last one flagged; the next
// request is taken while the final result of a tick still waits.
module multi_slot_advert_scheduler
	import msas_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	msas_in_if.sink    req,
	msas_out_if.source res
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign req.ready = in_ready;

	// Request sequencing.
	msas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot table and result path.
	msas_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_type (req.req_type),
		.slot     (req.slot),
		.tx_count (req.tx_count),
		.interval (req.interval),
		.adv_len  (req.adv_len),
		.res      (res)
	);

endmodule
